>>> rtl/core/pced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pced_pkg
// Shared types, constants and hex helpers for the percent-escape decoder.
// ----------------------------------------------------------------------------
package pced_pkg;

  localparam logic [7:0] PCT_CHAR  = 8'h25;
  localparam int         MAX_RES   = 3;
  localparam int         CNT_W     = 2;

  // Pending state of an escape sequence, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,  // nothing held
    PH_PCT  = 3'b010,  // '%' held
    PH_DIG  = 3'b100   // '%' and one hex digit held
  } pced_phase_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_end;
    logic       stream_end;
  } pced_entry_t;

  // Decoder result for one input transaction
  typedef struct packed {
    pced_entry_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]          cnt;
    pced_phase_t               phase_nxt;
    logic [7:0]                held_nxt;
  } pced_dec_t;

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Value of a hex digit; meaningful only when hex_ok is true
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c <= 8'h46) begin
      t = c - 8'h37;
    end else begin
      t = c - 8'h57;
    end
    hex_val = t[3:0];
  endfunction

endpackage

>>> rtl/core/pced_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pced_decode
// Combinational step: one input byte plus pending state gives up to three
// result bytes and the next pending state.
// ----------------------------------------------------------------------------
module pced_decode
  import pced_pkg::*;
(
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  pced_phase_t phase,
  input  logic [7:0]  held,
  output pced_dec_t   dec
);

  logic [MAX_RES-1:0][7:0] bytes;
  logic [CNT_W-1:0]        n;
  logic                    fresh;
  pced_phase_t             ph_nxt;
  logic [7:0]              hd_nxt;

  always_comb begin
    bytes  = '0;
    n      = '0;
    fresh  = 1'b0;
    ph_nxt = phase;
    hd_nxt = held;

    // Resolve the pending escape against the new byte
    unique case (phase)
      PH_PCT: begin
        if (hex_ok(in_byte)) begin
          hd_nxt = in_byte;
          ph_nxt = PH_DIG;
        end else begin
          bytes[0] = PCT_CHAR;
          n        = 2'd1;
          fresh    = 1'b1;
        end
      end
      PH_DIG: begin
        if (hex_ok(held) && hex_ok(in_byte)) begin
          bytes[0] = {hex_val(held), hex_val(in_byte)};
          n        = 2'd1;
          ph_nxt   = PH_IDLE;
        end else begin
          bytes[0] = PCT_CHAR;
          bytes[1] = held;
          n        = 2'd2;
          fresh    = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // Byte seen from a clean start
    if (fresh) begin
      if (in_byte == PCT_CHAR) begin
        ph_nxt = PH_PCT;
      end else begin
        bytes[n] = in_byte;
        n        = n + 2'd1;
        ph_nxt   = PH_IDLE;
      end
    end

    // Stream end: flush what is still held
    if (in_last) begin
      if (ph_nxt == PH_PCT) begin
        bytes[n] = PCT_CHAR;
        n        = n + 2'd1;
      end else if (ph_nxt == PH_DIG) begin
        bytes[n]         = PCT_CHAR;
        bytes[n + 2'd1]  = hd_nxt;
        n                = n + 2'd2;
      end
      ph_nxt = PH_IDLE;
      hd_nxt = 8'h00;
    end
  end

  // Pack entries, marking the final one of this transaction
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      dec.ent[i].byte_val   = bytes[i];
      dec.ent[i].run_end    = (n != 2'd0) && (CNT_W'(i) == n - 2'd1);
      dec.ent[i].stream_end = (n != 2'd0) && (CNT_W'(i) == n - 2'd1) && in_last;
    end
    dec.cnt       = n;
    dec.phase_nxt = ph_nxt;
    dec.held_nxt  = hd_nxt;
  end

endmodule

>>> rtl/core/percent_escape_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder_core
// First result of an input transaction is registered, valid the cycle after accept.
// Throughput: one input per cycle while each yields at most one result and
//   out_stall is low; an input yielding more stalls input until its last result leaves.
// Reset: synchronous active-low rst_n clears pending state and result count.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core
  import pced_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_stream_end
);

  pced_phase_t                phase_r;
  logic [7:0]                 held_r;
  pced_entry_t [MAX_RES-1:0]  buf_r;
  logic [CNT_W-1:0]           cnt_r;
  pced_dec_t                  dec;
  logic                       in_acc;
  logic                       out_acc;

  pced_decode u_decode (
    .in_byte (in_byte),
    .in_last (in_last),
    .phase   (phase_r),
    .held    (held_r),
    .dec     (dec)
  );

  // Handshakes: take a new transaction once the buffer drains this cycle
  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (cnt_r > 2'd1) || ((cnt_r == 2'd1) && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign out_byte       = buf_r[0].byte_val;
  assign out_run_end    = buf_r[0].run_end;
  assign out_stream_end = buf_r[0].stream_end;

  // Pending escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (in_acc) begin
      phase_r <= dec.phase_nxt;
      held_r  <= dec.held_nxt;
    end
  end

  // Result count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= dec.cnt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result buffer: load on accept, shift toward entry 0 on pop
  always_ff @(posedge clk) begin
    if (in_acc && dec.cnt != 2'd0) begin
      buf_r <= dec.ent;
    end else if (out_acc) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  // Stream end always produces at least one result
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid)
    else $error("no result after stream end transaction");

  // Pending state cleared after stream end
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> (phase_r == PH_IDLE) && (held_r == 8'h00))
    else $error("pending state not cleared at stream end");

  // Plain byte with nothing pending passes straight through
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (phase_r == PH_IDLE) && (in_byte != PCT_CHAR)
      |=> out_valid && (out_byte == $past(in_byte)))
    else $error("plain byte not passed through");

  // Only the entry at the head carrying run_end may be the last in buffer
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r == 2'd1) |-> out_run_end)
    else $error("last buffered result lacks run end mark");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for percent_escape_decoder_core. A directed table walks
// the escape cases after reset, then random streams of escapes, stray bytes
// and stream ends follow. Every output transaction is compared with a typed row's
// expectation or an in-bench decoder model, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import pced_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 104;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_SHOWN   = 10;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [7:0]             in_b;
    logic                   in_l;
    logic                   typed;
    logic [1:0]             n_typed;
    pced_entry_t [2:0]      ent;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic       out_stream_end;

  // Model state of the decoder
  pced_phase_t dec_phase = PH_IDLE;
  logic [7:0]  dec_held  = 8'h00;

  pced_entry_t step_out[$];    // results of the transaction just modeled
  pced_entry_t decoded_q[$];   // results still owed by the block
  dir_row_t    dir_rows[$];

  int  mismatches = 0;
  int  cyc        = 0;
  logic calm      = 1'b0;
  bit  hold_req   = 1'b0;

  percent_escape_decoder_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_end   (out_run_end),
    .out_stream_end(out_stream_end)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle counter, calm windows and run limit
  always @(posedge clk) begin
    cyc  <= cyc + 1;
    calm <= ((cyc / 300) % 4) == 2;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Digit value, -1 when c is not a strict hex digit
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic void emit_lit(input logic [7:0] b);
    pced_entry_t e;
    e.byte_val   = b;
    e.run_end    = 1'b0;
    e.stream_end = 1'b0;
    step_out.push_back(e);
  endfunction

  // Byte seen with nothing pending
  function automatic void take_fresh(input logic [7:0] b);
    if (b == PCT_CHAR) begin
      dec_phase = PH_PCT;
    end else begin
      dec_phase = PH_IDLE;
      emit_lit(b);
    end
  endfunction

  function automatic void decode_step(input logic [7:0] b, input logic lst);
    int hi;
    int lo;
    step_out.delete();
    case (dec_phase)
      PH_PCT: begin
        if (hex_digit(b) >= 0) begin
          dec_held  = b;
          dec_phase = PH_DIG;
        end else begin
          emit_lit(PCT_CHAR);
          take_fresh(b);
        end
      end
      PH_DIG: begin
        hi = hex_digit(dec_held);
        lo = hex_digit(b);
        if (hi >= 0 && lo >= 0) begin
          emit_lit(8'((hi << 4) | lo));
          dec_phase = PH_IDLE;
        end else begin
          // bad second digit: '%' and the held digit go out as literals
          emit_lit(PCT_CHAR);
          emit_lit(dec_held);
          take_fresh(b);
        end
      end
      default: take_fresh(b);
    endcase
    // stream end flushes whatever is pending
    if (lst) begin
      if (dec_phase == PH_PCT) begin
        emit_lit(PCT_CHAR);
      end else if (dec_phase == PH_DIG) begin
        emit_lit(PCT_CHAR);
        emit_lit(dec_held);
      end
      dec_phase = PH_IDLE;
      dec_held  = 8'h00;
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size()-1].run_end = 1'b1;
      if (lst) step_out[step_out.size()-1].stream_end = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pced_entry_t ent(input logic [7:0] b, input logic re,
                                      input logic se);
    pced_entry_t e;
    e.byte_val   = b;
    e.run_end    = re;
    e.stream_end = se;
    return e;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic l,
                                  input logic typed, input int n,
                                  input pced_entry_t e0 = '0,
                                  input pced_entry_t e1 = '0,
                                  input pced_entry_t e2 = '0);
    dir_row_t r;
    r.in_b    = b;
    r.in_l    = l;
    r.typed   = typed;
    r.n_typed = 2'(n);
    r.ent[0]  = e0;
    r.ent[1]  = e1;
    r.ent[2]  = e2;
    dir_rows.push_back(r);
  endfunction

  // Random byte biased toward escapes and the edges of the digit ranges
  function automatic logic [7:0] pick_byte();
    int r;
    logic [7:0] edges [10];
    edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h20, 8'h2B, 8'h2D, 8'h78};
    r = $urandom_range(0, 99);
    if (r < 30) return PCT_CHAR;
    if (r < 45) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 55) return 8'($urandom_range(8'h41, 8'h46));
    if (r < 65) return 8'($urandom_range(8'h61, 8'h66));
    if (r < 80) return edges[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int gap_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Offer one transaction and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic l, input int gap);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver back-pressure
  // ---------------------------------------------------------------------------
  initial begin
    int  r;
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall  <= 1'b1;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 25);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pced_entry_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_SHOWN)
          $display("[%0t] unexpected result: byte=%02h run_end=%0b stream_end=%0b",
                   $realtime, out_byte, out_run_end, out_stream_end);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.byte_val || out_run_end !== want.run_end ||
            out_stream_end !== want.stream_end) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_SHOWN)
            $display({"[%0t] mismatch: expected byte=%02h run_end=%0b stream_end=%0b,",
                      " got byte=%02h run_end=%0b stream_end=%0b"},
                     $realtime, want.byte_val, want.run_end, want.stream_end,
                     out_byte, out_run_end, out_stream_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] b;
    logic       l;
    int         g;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    in_last  <= 1'b0;

    // directed table: extremes, good and bad escapes, stream-end flushes
    add_row(8'h00, 1'b0, 1'b1, 1, ent(8'h00, 1'b1, 1'b0));
    add_row(8'hFF, 1'b0, 1'b1, 1, ent(8'hFF, 1'b1, 1'b0));
    add_row(PCT_CHAR, 1'b0, 1'b1, 0);
    add_row(8'h34, 1'b0, 1'b1, 0);                                   // '4'
    add_row(8'h31, 1'b0, 1'b1, 1, ent(8'h41, 1'b1, 1'b0));           // '1'
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(8'h61, 1'b0, 1'b0, 0);                                   // 'a'
    add_row(8'h46, 1'b0, 1'b0, 0);                                   // 'F'
    // bad first digit
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(8'h47, 1'b0, 1'b1, 2, ent(PCT_CHAR, 1'b0, 1'b0), ent(8'h47, 1'b1, 1'b0));
    // bad second digit
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(8'h32, 1'b0, 1'b0, 0);
    add_row(8'h7A, 1'b0, 1'b1, 3, ent(PCT_CHAR, 1'b0, 1'b0), ent(8'h32, 1'b0, 1'b0),
            ent(8'h7A, 1'b1, 1'b0));
    // '%' after '%' reopens an escape
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(PCT_CHAR, 1'b0, 1'b1, 1, ent(PCT_CHAR, 1'b1, 1'b0));
    add_row(8'h32, 1'b0, 1'b0, 0);
    add_row(8'h30, 1'b0, 1'b0, 0);
    // "0x" prefix and a sign never decode
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(8'h30, 1'b0, 1'b0, 0);
    add_row(8'h78, 1'b0, 1'b0, 0);
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(8'h2B, 1'b0, 1'b0, 0);
    // stream ends with nothing, a '%', or a '%' and a digit pending
    add_row(PCT_CHAR, 1'b1, 1'b1, 1, ent(PCT_CHAR, 1'b1, 1'b1));
    add_row(PCT_CHAR, 1'b0, 1'b0, 0);
    add_row(8'h39, 1'b1, 1'b1, 2, ent(PCT_CHAR, 1'b0, 1'b0), ent(8'h39, 1'b1, 1'b1));
    add_row(8'h78, 1'b1, 1'b1, 1, ent(8'h78, 1'b1, 1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].in_b, dir_rows[i].in_l, 0);
      decode_step(dir_rows[i].in_b, dir_rows[i].in_l);
      if (dir_rows[i].typed) begin
        for (int k = 0; k < dir_rows[i].n_typed; k++)
          decoded_q.push_back(dir_rows[i].ent[k]);
      end else begin
        foreach (step_out[k]) decoded_q.push_back(step_out[k]);
      end
      g = gap_cycles();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end

    // receiver holds off while the sender keeps offering back to back
    hold_req = 1'b1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      b = pick_byte();
      l = ($urandom_range(0, 9) == 0);
      g = (n < 24) ? 0 : gap_cycles();
      send_byte(b, l, 0);
      decode_step(b, l);
      foreach (step_out[k]) decoded_q.push_back(step_out[k]);
      if (n == 65) begin
        // sender pauses until the block has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
      end else if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
